[rtl/piecewise_poly_eval_core_assert.svh]
// Assertion macros used by the checker file of the evaluator.
`ifndef PIECEWISE_POLY_EVAL_CORE_ASSERT_SVH
`define PIECEWISE_POLY_EVAL_CORE_ASSERT_SVH

// Consequent checked at the next clock after the antecedent; uses clk and rst_n in scope.
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked at the same clock as the antecedent.
`define PPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/ppe_pkg.sv]
// Shared constants, word types and codes of the piecewise polynomial evaluator.
package ppe_pkg;

    localparam int MAX_PIECES = 32;
    localparam int MAX_ORDER  = 8;
    localparam int FRAC_BITS  = 16;
    localparam int Q_W        = 32;

    localparam int PIECE_W  = $clog2(MAX_PIECES);
    localparam int ORDER_W  = $clog2(MAX_ORDER);
    localparam int BRK_AW   = $clog2(MAX_PIECES + 1);
    localparam int COEF_AW  = PIECE_W + ORDER_W;
    localparam int NP_W     = 6;
    localparam int ORD_W    = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIECES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_ORDER = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD_BRK  = 2'd0,
        OP_LOAD_COEF = 2'd1,
        OP_EVAL      = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [5:0]            piece_index;
        logic [2:0]            power_index;
        logic signed [Q_W-1:0] data_value;
        logic signed [Q_W-1:0] query_x;
    } cmd_word_t;

    typedef struct packed {
        logic signed [Q_W-1:0] y_value;
        logic                  overflow;
    } rsp_word_t;

    typedef struct packed {
        logic load_u;
        logic load_y0;
        logic mul;
        logic add;
    } horner_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B0,
        ST_BN,
        ST_BCHK,
        ST_SCAN,
        ST_BJ,
        ST_U,
        ST_C0,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

endpackage

[rtl/ppe_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ppe_horner.sv]
// Horner datapath: offset, registered multiply, shift, add and saturate.
module ppe_horner (
    input  logic                           clk,
    input  ppe_pkg::horner_ctl_t           ctl,
    input  logic signed [ppe_pkg::Q_W-1:0] x,
    input  logic signed [ppe_pkg::Q_W-1:0] brk,
    input  logic signed [ppe_pkg::Q_W-1:0] coef,
    output logic signed [ppe_pkg::Q_W-1:0] y,
    output logic                           ovf
);
    import ppe_pkg::*;

    localparam int PROD_W = 2 * Q_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W  = SH_W + 1;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    logic signed [Q_W-1:0]    u_reg, u_next;
    logic signed [Q_W-1:0]    y_reg, y_next;
    logic                     ovf_reg, ovf_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Q_W:0]      diff;
    logic signed [SH_W-1:0]   shifted;
    logic signed [SUM_W-1:0]  sum;
    logic                     diff_ovf;
    logic                     sum_ovf;

    always_comb
    begin
        diff     = (Q_W+1)'(x) - (Q_W+1)'(brk);
        diff_ovf = diff[Q_W] != diff[Q_W-1];
        shifted  = SH_W'(prod_reg >>> FRAC_BITS);
        sum      = SUM_W'(shifted) + SUM_W'(coef);
        // in range only when every bit from the sign down to bit Q_W-1 agrees
        sum_ovf  = !((&sum[SUM_W-1:Q_W-1]) || !(|sum[SUM_W-1:Q_W-1]));

        u_next   = u_reg;
        y_next   = y_reg;
        ovf_next = ovf_reg;
        if (ctl.load_u)
        begin
            u_next   = diff_ovf ? (diff[Q_W] ? Q_MIN : Q_MAX) : diff[Q_W-1:0];
            ovf_next = diff_ovf;
        end
        if (ctl.load_y0)
        begin
            y_next = coef;
        end
        if (ctl.add)
        begin
            y_next   = sum_ovf ? (sum[SUM_W-1] ? Q_MIN : Q_MAX) : sum[Q_W-1:0];
            ovf_next = ovf_reg | sum_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        y_reg   <= y_next;
        ovf_reg <= ovf_next;
        if (ctl.mul)
        begin
            prod_reg <= PROD_W'(y_reg) * PROD_W'(u_reg);
        end
    end

    assign y   = y_reg;
    assign ovf = ovf_reg;

endmodule

[rtl/piecewise_poly_eval_core.sv]
// Top level of the piecewise polynomial evaluator: tables, sequencer and result register.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_word) carries load-breakpoint,
//   load-coefficient and evaluate words. A word is taken on a rising edge with
//   cmd_valid high and cmd_stall low. Loads return nothing.
//   rsp channel (rsp_valid / rsp_stall / rsp_word) returns one word per query:
//   the saturated Q16.16 value and an overflow flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets num_pieces
//   (index 0) and poly_order (index 1); cfg_ready is always high. Write it only
//   while no query is in flight.
// Sequence: a query reads the first and the last breakpoint and, when x lies between
//   them, scans the upper breakpoints with one breakpoint-memory read per scan step;
//   each Horner step is a registered multiply, then shift, add and saturate.
// Reset clears the sequencer and the result valid flag and resets the configuration
//   (num_pieces 1, poly_order 4); the tables keep whatever they held.
// A stalled result holds in the output register; loads are still taken, and a
//   following query finishes its work and waits until that register frees up.
module piecewise_poly_eval_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  ppe_pkg::cmd_word_t                  cmd_word,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ppe_pkg::rsp_word_t                  rsp_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppe_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ppe_pkg::*;

    state_t                state_reg, state_next;
    logic signed [Q_W-1:0] x_reg, x_next;
    logic [NP_W-1:0]       np_reg, np_next;
    logic [ORD_W-1:0]      ord_reg, ord_next;
    logic [PIECE_W-1:0]    j_reg, j_next;
    logic [NP_W-1:0]       cnt_reg, cnt_next;
    logic [ORDER_W-1:0]    k_reg, k_next;
    logic                  le0_reg, le0_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_word_t             rsp_word_reg, rsp_word_next;
    logic [NP_W-1:0]       num_pieces_reg;
    logic [ORD_W-1:0]      poly_order_reg;

    logic                  cmd_accept;
    logic [NP_W-1:0]       np_eff;
    logic [ORD_W-1:0]      ord_eff;

    logic                  brk_we, brk_re;
    logic [BRK_AW-1:0]     brk_raddr;
    logic [Q_W-1:0]        brk_rdata;
    logic                  coef_we, coef_re;
    logic [COEF_AW-1:0]    coef_raddr;
    logic [Q_W-1:0]        coef_rdata;
    logic signed [Q_W-1:0] brk_val;

    horner_ctl_t           hctl;
    logic signed [Q_W-1:0] h_y;
    logic                  h_ovf;

    // ---------------------------------------------------------------- input side
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    // Loads write straight into the tables; out-of-range indexes drop the word.
    assign brk_we  = cmd_accept && (cmd_word.opcode == OP_LOAD_BRK)
                     && (int'(cmd_word.piece_index) <= MAX_PIECES);
    assign coef_we = cmd_accept && (cmd_word.opcode == OP_LOAD_COEF)
                     && (int'(cmd_word.piece_index) < MAX_PIECES)
                     && (int'(cmd_word.power_index) < MAX_ORDER);

    // Clamp the configuration into its usable range when a query starts.
    always_comb
    begin
        if (num_pieces_reg == '0)
            np_eff = NP_W'(1);
        else if (int'(num_pieces_reg) > MAX_PIECES)
            np_eff = NP_W'(MAX_PIECES);
        else
            np_eff = num_pieces_reg;

        if (poly_order_reg == '0)
            ord_eff = ORD_W'(1);
        else if (int'(poly_order_reg) > MAX_ORDER)
            ord_eff = ORD_W'(MAX_ORDER);
        else
            ord_eff = poly_order_reg;
    end

    // ---------------------------------------------------------------- tables
    ppe_ram #(
        .WIDTH (Q_W),
        .DEPTH (MAX_PIECES + 1),
        .AW    (BRK_AW)
    ) u_brk_ram (
        .clk   (clk),
        .we    (brk_we),
        .waddr (BRK_AW'(cmd_word.piece_index)),
        .wdata (cmd_word.data_value),
        .re    (brk_re),
        .raddr (brk_raddr),
        .rdata (brk_rdata)
    );

    ppe_ram #(
        .WIDTH (Q_W),
        .DEPTH (MAX_PIECES * MAX_ORDER),
        .AW    (COEF_AW)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr ({cmd_word.piece_index[PIECE_W-1:0], cmd_word.power_index[ORDER_W-1:0]}),
        .wdata (cmd_word.data_value),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    assign brk_val = $signed(brk_rdata);

    // ---------------------------------------------------------------- Horner unit
    ppe_horner u_horner (
        .clk  (clk),
        .ctl  (hctl),
        .x    (x_reg),
        .brk  (brk_val),
        .coef ($signed(coef_rdata)),
        .y    (h_y),
        .ovf  (h_ovf)
    );

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        np_reg       <= np_next;
        ord_reg      <= ord_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        le0_reg      <= le0_next;
        rsp_word_reg <= rsp_word_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        np_next        = np_reg;
        ord_next       = ord_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        le0_next       = le0_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        brk_re         = 1'b0;
        brk_raddr      = '0;
        coef_re        = 1'b0;
        coef_raddr     = '0;
        hctl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept && (cmd_word.opcode == OP_EVAL))
                begin
                    x_next     = cmd_word.query_x;
                    np_next    = np_eff;
                    ord_next   = ord_eff;
                    state_next = ST_B0;
                end
            end
            ST_B0:
            begin
                brk_re     = 1'b1;
                brk_raddr  = '0;
                state_next = ST_BN;
            end
            ST_BN:
            begin
                // first breakpoint is back; fetch the last one
                le0_next   = (x_reg <= brk_val);
                brk_re     = 1'b1;
                brk_raddr  = BRK_AW'(np_reg);
                state_next = ST_BCHK;
            end
            ST_BCHK:
            begin
                if (le0_reg)
                begin
                    j_next     = '0;
                    state_next = ST_BJ;
                end
                else if (x_reg >= brk_val)
                begin
                    j_next     = PIECE_W'(np_reg - NP_W'(1));
                    state_next = ST_BJ;
                end
                else
                begin
                    brk_re     = 1'b1;
                    brk_raddr  = BRK_AW'(1);
                    cnt_next   = NP_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one upper breakpoint per cycle, stop at the first one above x or at the last one
                if (x_reg < brk_val)
                begin
                    j_next     = PIECE_W'(cnt_reg - NP_W'(1));
                    state_next = ST_BJ;
                end
                else if (cnt_reg == np_reg)
                begin
                    j_next     = PIECE_W'(np_reg - NP_W'(1));
                    state_next = ST_BJ;
                end
                else
                begin
                    brk_re     = 1'b1;
                    brk_raddr  = BRK_AW'(cnt_reg + NP_W'(1));
                    cnt_next   = cnt_reg + NP_W'(1);
                end
            end
            ST_BJ:
            begin
                brk_re     = 1'b1;
                brk_raddr  = BRK_AW'(j_reg);
                state_next = ST_U;
            end
            ST_U:
            begin
                hctl.load_u = 1'b1;
                coef_re     = 1'b1;
                coef_raddr  = {j_reg, ORDER_W'(0)};
                state_next  = ST_C0;
            end
            ST_C0:
            begin
                hctl.load_y0 = 1'b1;
                if (ord_reg == ORD_W'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    coef_re    = 1'b1;
                    coef_raddr = {j_reg, ORDER_W'(1)};
                    k_next     = ORDER_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                hctl.mul   = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                hctl.add = 1'b1;
                if (ORD_W'(k_reg) == ord_reg - ORD_W'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    coef_re    = 1'b1;
                    coef_raddr = {j_reg, k_reg + ORDER_W'(1)};
                    k_next     = k_reg + ORDER_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // hold here until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_word_next.y_value  = h_y;
                    rsp_word_next.overflow = h_ovf;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // ---------------------------------------------------------------- configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pieces_reg <= NP_W'(1);
            poly_order_reg <= ORD_W'(4);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NUM_PIECES: num_pieces_reg <= cfg_data[NP_W-1:0];
                CFG_POLY_ORDER: poly_order_reg <= cfg_data[ORD_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

[rtl/ppe_checker.sv]
// Port-level checker for the evaluator, bound to the top level.
`include "piecewise_poly_eval_core_assert.svh"

module ppe_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_stall,
    input ppe_pkg::cmd_word_t             cmd_word,
    input logic                           rsp_valid,
    input logic                           rsp_stall,
    input ppe_pkg::rsp_word_t             rsp_word,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);
    import ppe_pkg::*;

    `PPE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled response word dropped")
    `PPE_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_word), "stalled response word changed")
    `PPE_ASSERT_NEXT(a_eval_busy, cmd_valid && !cmd_stall && cmd_word.opcode == OP_EVAL, cmd_stall, "query taken but block not busy")
    `PPE_ASSERT_NOW(a_rsp_after_busy, $rose(rsp_valid), $past(cmd_stall), "response word without a query in flight")
    `PPE_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !cmd_stall, "register written mid-query")

endmodule

bind piecewise_poly_eval_core ppe_checker u_ppe_checker (.*);

[tb/tb_piecewise_poly_eval_core.sv]
// Self-checking testbench for the piecewise polynomial evaluator core.
`timescale 1ns / 100ps

module tb_piecewise_poly_eval_core;
    import ppe_pkg::*;

    // Opcode and register index that the block must ignore
    localparam logic [1:0]           OP_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd2;

    // Settle a little past the longest query
    localparam int QUERY_CYCLES_MAX = 53;
    localparam int SETTLE_CYCLES    = QUERY_CYCLES_MAX + 8;
    localparam int IDLE_LIMIT       = 4000;
    localparam int MAX_GAP          = 18;
    localparam int MAX_REPORTS      = 40;
    localparam int PHASE_ITEMS      = 60;
    localparam int RANDOM_PHASES    = 9;

    localparam logic signed [Q_W-1:0] Q_POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_NEG_MAX = 32'sh8000_0000;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cmd_valid;
    logic                   cmd_stall;
    cmd_word_t              cmd_word;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_word_t              rsp_word;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the tables and the configuration
    logic signed [Q_W-1:0]  brk_mem  [0:MAX_PIECES];
    logic signed [Q_W-1:0]  coef_mem [0:MAX_PIECES*MAX_ORDER-1];
    logic [NP_W-1:0]        np_reg;
    logic [ORD_W-1:0]       ord_reg;

    // Values the pending queries should return, oldest first
    rsp_word_t              pending_y_q [$];
    rsp_word_t              want_w;

    int                     error_count     = 0;
    int                     queries_checked = 0;
    int                     loads_sent      = 0;
    int                     ignored_sent    = 0;
    int                     cfg_writes      = 0;
    int                     idle_cycles     = 0;
    int                     rsp_hold        = 0;
    bit                     rsp_took        = 1'b1;
    bit                     send_burst      = 1'b0;
    bit                     rsp_burst       = 1'b0;

    piecewise_poly_eval_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp to 32 bits, flag when clamped
    function automatic longint clamp_q(input longint v, inout bit ovf);
        if (v > SAT_HI)
        begin
            ovf = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            ovf = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // Piece lookup followed by a Horner evaluation at the offset from the piece start
    function automatic rsp_word_t eval_poly(input logic signed [Q_W-1:0] x);
        int        np;
        int        ord;
        int        j;
        int        k;
        bit        found;
        bit        ovf;
        longint    u;
        longint    y;
        longint    prod;
        rsp_word_t r;
        np = int'(np_reg);
        ord = int'(ord_reg);
        if (np < 1) np = 1;
        if (np > MAX_PIECES) np = MAX_PIECES;
        if (ord < 1) ord = 1;
        if (ord > MAX_ORDER) ord = MAX_ORDER;
        // End pieces extrapolate; otherwise take the first upper break above x
        if (x <= brk_mem[0])
            j = 0;
        else if (x >= brk_mem[np])
            j = np - 1;
        else
        begin
            j = np - 1;
            found = 1'b0;
            for (k = 0; k < np; k++)
            begin
                if (!found && x < brk_mem[k+1])
                begin
                    j = k;
                    found = 1'b1;
                end
            end
        end
        ovf = 1'b0;
        u = clamp_q(longint'(x) - longint'(brk_mem[j]), ovf);
        y = longint'(coef_mem[j*MAX_ORDER]);
        for (k = 1; k < ord; k++)
        begin
            // Arithmetic shift truncates toward minus infinity
            prod = (y * u) >>> FRAC_BITS;
            y = clamp_q(prod + longint'(coef_mem[j*MAX_ORDER+k]), ovf);
        end
        r.y_value = y[Q_W-1:0];
        r.overflow = ovf;
        return r;
    endfunction

    // Apply one accepted word to the shadow state
    task automatic apply_word(input cmd_word_t w);
        case (w.opcode)
            OP_LOAD_BRK:
            begin
                if (w.piece_index <= MAX_PIECES)
                    brk_mem[w.piece_index] = w.data_value;
                loads_sent++;
            end
            OP_LOAD_COEF:
            begin
                if (w.piece_index < MAX_PIECES && w.power_index < MAX_ORDER)
                    coef_mem[int'(w.piece_index)*MAX_ORDER + int'(w.power_index)] = w.data_value;
                loads_sent++;
            end
            OP_EVAL:
                pending_y_q.push_back(eval_poly(w.query_x));
            default:
                ignored_sent++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic cmd_word_t make_cmd(input logic [1:0] op, input logic [5:0] pi,
                                           input logic [2:0] pw, input logic [31:0] d,
                                           input logic [31:0] x);
        cmd_word_t w;
        w.opcode      = op;
        w.piece_index = pi;
        w.power_index = pw;
        w.data_value  = d;
        w.query_x     = x;
        return w;
    endfunction

    function automatic int draw_gap();
        if (send_burst)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Send one command word; valid stays up after acceptance until the next falling edge
    task automatic send_word(input cmd_word_t w);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        apply_word(w);
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_y_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_NUM_PIECES)
            np_reg = val[NP_W-1:0];
        else if (idx == CFG_POLY_ORDER)
            ord_reg = val[ORD_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Idle the block, then write both registers; upper data bits are noise
    task automatic set_config(input int np, input int ord);
        logic [CFG_DATA_W-1:0] v;
        wait_idle();
        v = CFG_DATA_W'($urandom);
        v[NP_W-1:0] = np[NP_W-1:0];
        cfg_write(CFG_NUM_PIECES, v);
        v = CFG_DATA_W'($urandom);
        v[ORD_W-1:0] = ord[ORD_W-1:0];
        cfg_write(CFG_POLY_ORDER, v);
    endtask

    // Query point: mostly near a breakpoint in use, sometimes the extremes or anywhere
    function automatic logic signed [Q_W-1:0] pick_x();
        int np;
        int k;
        np = int'(np_reg);
        if (np < 1) np = 1;
        if (np > MAX_PIECES) np = MAX_PIECES;
        k = $urandom_range(0, np);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? Q_POS_MAX : Q_NEG_MAX;
            2:       return brk_mem[k];
            default: return brk_mem[k] + 32'($urandom_range(0, 1024)) - 32'd512;
        endcase
    endfunction

    // Coefficients mostly within +/-2.0 so Horner chains stay in range
    function automatic logic [31:0] pick_coef();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
    endfunction

    // Rewrite all breakpoints, ascending (steps of zero allowed) or scrambled
    task automatic load_breaks(input bit sorted);
        longint b;
        int     i;
        b = -longint'($urandom_range(0, 32'h80000));
        for (i = 0; i <= MAX_PIECES; i++)
        begin
            if (sorted)
            begin
                send_word(make_cmd(OP_LOAD_BRK, 6'(i), 3'($urandom), b[31:0], $urandom));
                b = b + $urandom_range(0, 32'h30000);
            end
            else
                send_word(make_cmd(OP_LOAD_BRK, 6'(i), 3'($urandom), $urandom, $urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Compare every taken result against the oldest pending prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_took = 1'b1;
            if (pending_y_q.size() == 0)
                report_mismatch($sformatf("result with no query pending: y=%h ovf=%b",
                                          rsp_word.y_value, rsp_word.overflow));
            else
            begin
                want_w = pending_y_q.pop_front();
                if (rsp_word.y_value !== want_w.y_value)
                    report_mismatch($sformatf("y_value got %h want %h",
                                              rsp_word.y_value, want_w.y_value));
                if (rsp_word.overflow !== want_w.overflow)
                    report_mismatch($sformatf("overflow got %b want %b (y %h)",
                                              rsp_word.overflow, want_w.overflow,
                                              want_w.y_value));
                queries_checked++;
            end
        end
    end

    // Hold off the result side a random number of cycles after each taken word
    always @(negedge clk)
    begin
        if (rsp_took)
        begin
            rsp_took = 1'b0;
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (rsp_hold > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold--;
        end
        else
            rsp_stall <= 1'b0;
    end

    // Watchdog: end the run when no channel moves a word for too long
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
                         $realtime, IDLE_LIMIT, pending_y_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Write every table entry once so no query can read an unwritten one
    task automatic test_table_fill();
        int p;
        int k;
        load_breaks(1'b1);
        for (p = 0; p < MAX_PIECES; p++)
            for (k = 0; k < MAX_ORDER; k++)
                send_word(make_cmd(OP_LOAD_COEF, 6'(p), 3'(k), pick_coef(), $urandom));
    endtask

    // Reset configuration, field extremes, saturation and the ignored words
    task automatic test_directed();
        // Queries under the reset configuration (one piece, four coefficients)
        send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, Q_NEG_MAX));
        send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, brk_mem[1]));

        set_config(4, 3);
        send_word(make_cmd(OP_LOAD_BRK, 6'd0, 3'($urandom), Q_NEG_MAX, $urandom));
        send_word(make_cmd(OP_LOAD_BRK, 6'd1, 3'($urandom), 32'h0000_0000, $urandom));
        send_word(make_cmd(OP_LOAD_BRK, 6'd2, 3'($urandom), 32'h0001_0000, $urandom));
        send_word(make_cmd(OP_LOAD_BRK, 6'd3, 3'($urandom), 32'h0002_0000, $urandom));
        send_word(make_cmd(OP_LOAD_BRK, 6'd4, 3'($urandom), Q_POS_MAX, $urandom));
        // Piece 0 coefficients at full scale so Horner steps at a large offset saturate
        send_word(make_cmd(OP_LOAD_COEF, 6'd0, 3'd0, Q_POS_MAX, $urandom));
        send_word(make_cmd(OP_LOAD_COEF, 6'd0, 3'd1, Q_POS_MAX, $urandom));
        send_word(make_cmd(OP_LOAD_COEF, 6'd0, 3'd2, Q_NEG_MAX, $urandom));
        send_word(make_cmd(OP_LOAD_COEF, 6'd3, 3'd0, 32'h0001_0000, $urandom));
        send_word(make_cmd(OP_LOAD_COEF, 6'd3, 3'd1, 32'h0000_0000, $urandom));
        send_word(make_cmd(OP_LOAD_COEF, 6'd3, 3'd2, 32'h0000_8000, $urandom));
        send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, Q_NEG_MAX));
        send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, Q_POS_MAX));
        send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, 32'h0000_0000));
        send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, 32'h0001_0000));
        send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, 32'hFFFF_FFFF));
        // Words the block must drop without touching the tables
        send_word(make_cmd(OP_RESERVED, 6'($urandom), 3'($urandom), $urandom, $urandom));
        send_word(make_cmd(OP_LOAD_BRK, 6'd33, 3'($urandom), $urandom, $urandom));
        send_word(make_cmd(OP_LOAD_BRK, 6'd63, 3'($urandom), $urandom, $urandom));
        send_word(make_cmd(OP_LOAD_COEF, 6'd32, 3'd0, $urandom, $urandom));
        send_word(make_cmd(OP_LOAD_COEF, 6'd63, 3'd7, $urandom, $urandom));
        // First break far above the query: the offset itself saturates
        send_word(make_cmd(OP_LOAD_BRK, 6'd0, 3'($urandom), 32'h7FFF_0000, $urandom));
        send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, Q_NEG_MAX));
    endtask

    // Extreme and out-of-range register values, including zero and all ones
    task automatic test_config_extremes();
        int np_set  [6] = '{1, 32, 0, 63, 33, 5};
        int ord_set [6] = '{1, 8, 0, 15, 9, 2};
        int c;
        int n;
        for (c = 0; c < 6; c++)
        begin
            set_config(np_set[c], ord_set[c]);
            if (c == 2)
                cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
            send_burst = (c == 1);
            rsp_burst  = (c == 1) || (c == 4);
            for (n = 0; n < 20; n++)
                send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom, pick_x()));
        end
        send_burst = 1'b0;
        rsp_burst  = 1'b0;
    endtask

    // Random phases: fresh config, optional new breakpoints, then mixed traffic
    task automatic test_random_traffic();
        int         ph;
        int         n;
        int         r;
        int         pi;
        logic [5:0] raw_pi;
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_config($urandom_range(0, 63), $urandom_range(0, 15));
            send_burst = ($urandom_range(0, 3) == 0);
            rsp_burst  = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 5);
            if (r < 2)
                load_breaks(1'b1);
            else if (r == 2)
                load_breaks(1'b0);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                raw_pi = 6'($urandom);
                if (r < 55)
                    send_word(make_cmd(OP_EVAL, 6'($urandom), 3'($urandom), $urandom,
                                       pick_x()));
                else if (r < 75)
                    send_word(make_cmd(OP_LOAD_COEF, 6'($urandom_range(0, MAX_PIECES - 1)),
                                       3'($urandom), pick_coef(), $urandom));
                else if (r < 85)
                begin
                    // Nudge a breakpoint so the table stays roughly ordered
                    pi = $urandom_range(0, MAX_PIECES);
                    send_word(make_cmd(OP_LOAD_BRK, 6'(pi), 3'($urandom),
                                       brk_mem[pi] + 32'($urandom_range(0, 4096)) - 32'd2048,
                                       $urandom));
                end
                else if (r < 90)
                    send_word(make_cmd(OP_LOAD_BRK, raw_pi, 3'($urandom),
                                       $urandom, $urandom));
                else if (r < 95)
                    send_word(make_cmd(OP_LOAD_COEF, raw_pi, 3'($urandom), pick_coef(),
                                       $urandom));
                else
                    send_word(make_cmd(OP_RESERVED, 6'($urandom), 3'($urandom), $urandom,
                                       $urandom));
            end
        end
        send_burst = 1'b0;
        rsp_burst  = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_word  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        np_reg    = NP_W'(1);
        ord_reg   = ORD_W'(4);
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_table_fill();
        test_directed();
        test_config_extremes();
        test_random_traffic();
        wait_idle();

        if (pending_y_q.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived", pending_y_q.size()));

        $display("Covered %0d queries checked, %0d table loads, %0d ignored words,",
                 queries_checked, loads_sent, ignored_sent);
        $display("%0d register writes across extreme and random settings; %0d mismatches.",
                 cfg_writes, error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
